>>> src/ctb_pkg.sv
// Package: constants and shared types for the Cartesian tree builder.
`default_nettype none
package ctb_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int OUT_W     = 10;
  localparam int PRIO_W    = 32;

  typedef struct packed {
    logic signed [PRIO_W-1:0] priority_req;
    logic                     start_tree;
  } in_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] node_index;
    logic [OUT_W-1:0] parent_index;
    logic             has_parent;
    logic [OUT_W-1:0] left_index;
    logic             has_left;
    logic [OUT_W-1:0] root_index;
    logic             overflow;
  } out_res_t;

  // Right-child link of a node, carrying the child's priority along.
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         idx;
    logic signed [PRIO_W-1:0] prio;
  } link_t;

  localparam int LINK_W = $bits(link_t);

endpackage
`default_nettype wire

>>> src/ctb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/cartesian_tree_builder.sv
// Top level: max-heap Cartesian tree builder over a right-spine link memory.
`default_nettype none
// Accepts one priority per request, in key order, numbers the nodes 0, 1, 2, ...
// and returns the new node's parent, left child and the current root. Each
// node's right-child link (with the child's priority) lives in one RAM with a
// registered read; the last node's and the root's priorities sit in registers.
// A request on a full tree goes straight to emit; else the node's link is
// cleared, then a node under the previous node writes that node's link, and a
// spine walk reads one spine link per cycle until it writes the new link.
// The result sits in an output register, so the next request is taken while it
// waits. No clearing pass is needed after reset.
module cartesian_tree_builder
  import ctb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_res_t      out_res
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_LINK, S_CHK, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_FIRST, K_BELOW, K_ROOT, K_WALK
  } kind_t;

  state_t                   state_r;
  kind_t                    kind_r;
  logic [CNT_W-1:0]         count_r;
  logic [IDX_W-1:0]         root_r;
  logic [IDX_W-1:0]         prev_r;
  logic signed [PRIO_W-1:0] root_prio_r;
  logic signed [PRIO_W-1:0] prev_prio_r;
  logic signed [PRIO_W-1:0] key_r;
  logic [IDX_W-1:0]         me_r;
  logic [IDX_W-1:0]         par_r;
  logic [IDX_W-1:0]         at_r;
  out_res_t                 res_r;
  out_res_t                 out_res_r;
  logic                     out_valid_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  link_t             wr_link;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [LINK_W-1:0] rd_data;
  link_t             rd_link;
  link_t             new_link;
  logic              walk_on;

  logic             in_acc;
  logic [CNT_W-1:0] cnt_eff;
  logic             full;
  logic [IDX_W-1:0] me;

  ctb_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_NODES)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_link),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE) | ~rst_n;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign cnt_eff = in_req.start_tree ? '0 : count_r;
  assign full    = (cnt_eff == CNT_W'(MAX_NODES));
  assign me      = cnt_eff[IDX_W-1:0];

  assign rd_link  = link_t'(rd_data);
  assign new_link = '{valid: 1'b1, idx: me_r, prio: key_r};
  assign walk_on  = rd_link.valid && (rd_link.prio > key_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = me_r;
    wr_link = '0;
    rd_en   = 1'b0;
    rd_addr = at_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = me_r;
        wr_link = '0;
        rd_en   = (kind_r == K_WALK);
        rd_addr = at_r;
      end
      S_LINK: begin
        wr_en   = 1'b1;
        wr_addr = par_r;
        wr_link = new_link;
      end
      S_CHK: begin
        if (walk_on) begin
          rd_en   = 1'b1;
          rd_addr = rd_link.idx;
        end else begin
          wr_en   = 1'b1;
          wr_addr = at_r;
          wr_link = new_link;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (full) begin
              res_r   <= '{node_index: '0, parent_index: '0, has_parent: 1'b0,
                           left_index: '0, has_left: 1'b0,
                           root_index: OUT_W'(root_r), overflow: 1'b1};
              state_r <= S_EMIT;
            end else begin
              key_r       <= in_req.priority_req;
              me_r        <= me;
              prev_r      <= me;
              prev_prio_r <= in_req.priority_req;
              count_r     <= cnt_eff + CNT_W'(1);
              state_r     <= S_CLEAR;
              if (me == '0) begin
                kind_r      <= K_FIRST;
                root_r      <= '0;
                root_prio_r <= in_req.priority_req;
                res_r       <= '{node_index: OUT_W'(me), parent_index: '0,
                                 has_parent: 1'b0, left_index: '0, has_left: 1'b0,
                                 root_index: '0, overflow: 1'b0};
              end else if (in_req.priority_req < prev_prio_r) begin
                kind_r <= K_BELOW;
                par_r  <= prev_r;
                res_r  <= '{node_index: OUT_W'(me), parent_index: OUT_W'(prev_r),
                            has_parent: 1'b1, left_index: '0, has_left: 1'b0,
                            root_index: OUT_W'(root_r), overflow: 1'b0};
              end else if (root_prio_r < in_req.priority_req) begin
                kind_r      <= K_ROOT;
                root_r      <= me;
                root_prio_r <= in_req.priority_req;
                res_r       <= '{node_index: OUT_W'(me), parent_index: '0,
                                 has_parent: 1'b0, left_index: OUT_W'(root_r),
                                 has_left: 1'b1, root_index: OUT_W'(me),
                                 overflow: 1'b0};
              end else begin
                kind_r <= K_WALK;
                at_r   <= root_r;
                res_r  <= '{node_index: OUT_W'(me), parent_index: '0,
                            has_parent: 1'b0, left_index: '0, has_left: 1'b0,
                            root_index: OUT_W'(root_r), overflow: 1'b0};
              end
            end
          end
        end
        S_CLEAR: begin
          if (kind_r == K_BELOW) begin
            state_r <= S_LINK;
          end else if (kind_r == K_WALK) begin
            state_r <= S_CHK;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_LINK: begin
          state_r <= S_EMIT;
        end
        S_CHK: begin
          if (walk_on) begin
            at_r <= rd_link.idx;
          end else begin
            res_r   <= '{node_index: res_r.node_index, parent_index: OUT_W'(at_r),
                         has_parent: 1'b1,
                         left_index: rd_link.valid ? OUT_W'(rd_link.idx) : '0,
                         has_left: rd_link.valid, root_index: res_r.root_index,
                         overflow: 1'b0};
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_res_r <= res_r;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NODES))
    else $error("node count beyond capacity");

  a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.overflow |-> !out_res.has_parent && !out_res.has_left)
    else $error("overflow result carries links");

  a_orphan_is_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.overflow && !out_res.has_parent |->
      out_res.root_index == out_res.node_index)
    else $error("parentless node is not the root");

  a_walk_writes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK && !walk_on |-> wr_en && wr_addr == at_r)
    else $error("walk end without link write");
`endif

endmodule
`default_nettype wire
